/* src/hdp_pkg.sv */
`default_nettype none
package hdp_pkg;

    // descriptor type code of a hub descriptor
    localparam logic [7:0] HUB_DESC_TYPE = 8'h29;
    localparam logic [7:0] MIN_DESC_LEN  = 8'd7;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    // byte offsets within the descriptor
    localparam logic [7:0] OFS_LEN     = 8'd0;
    localparam logic [7:0] OFS_TYPE    = 8'd1;
    localparam logic [7:0] OFS_PORTS   = 8'd2;
    localparam logic [7:0] OFS_CHAR_LO = 8'd3;
    localparam logic [7:0] OFS_CHAR_HI = 8'd4;
    localparam logic [7:0] OFS_PGOOD   = 8'd5;
    localparam logic [7:0] OFS_CURR    = 8'd6;

    // power switching modes, characteristics bits 1:0
    localparam logic [1:0] PWR_INDIV = 2'd1;
    localparam logic [1:0] PWR_NONE  = 2'd2;
    localparam logic [1:0] PWR_BAD   = 2'd3;

    localparam int COMPOUND_BIT = 2;
    localparam int THINK_LO     = 5;
    localparam int MULTI_TT_BIT = 7;

    typedef struct packed {
        logic [7:0]  count;
        logic [7:0]  len;
        logic [7:0]  typ;
        logic [7:0]  ports;
        logic [15:0] char_w;
        logic [7:0]  pgood;
        logic [7:0]  curr;
    } t_hdr;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] characteristics_word;
        logic [7:0]  num_ports;
        logic [7:0]  power_good_time;
        logic [7:0]  controller_current;
        logic        per_port_power;
        logic        no_power_switch;
        logic        compound_device;
        logic [1:0]  think_time;
        logic        multiple_tt;
    } t_res;

endpackage
`default_nettype wire

/* src/hdp_in_if.sv */
`default_nettype none
interface hdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* src/hdp_out_if.sv */
`default_nettype none
interface hdp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [15:0] characteristics_word;
    logic [7:0]  num_ports;
    logic [7:0]  power_good_time;
    logic [7:0]  controller_current;
    logic        per_port_power;
    logic        no_power_switch;
    logic        compound_device;
    logic [1:0]  think_time;
    logic        multiple_tt;

    modport source (
        output valid, output valid_res, output characteristics_word, output num_ports,
        output power_good_time, output controller_current, output per_port_power,
        output no_power_switch, output compound_device, output think_time,
        output multiple_tt, input ready
    );
    modport sink (
        input valid, input valid_res, input characteristics_word, input num_ports,
        input power_good_time, input controller_current, input per_port_power,
        input no_power_switch, input compound_device, input think_time,
        input multiple_tt, output ready
    );
endinterface
`default_nettype wire

/* src/usb_hub_descriptor_parser.sv */
`default_nettype none
// Hub descriptor parser. Takes one descriptor byte per word on i_in, with
// last_byte marking the buffer's final byte, and gives one result word on
// o_out per buffer. Throughput is one byte per clock: the header latches and
// the saturating byte counter update in the cycle a word is taken, and the
// checks run on the final byte on their way into the result register, so the
// result shows in the cycle after the final byte is taken. i_in stalls only
// while a finished result sits in the output register and o_out.ready is low;
// a result taken in the same cycle frees the slot for the next final byte.
// valid_res is high when the buffer holds at least 7 bytes, the type is 0x29,
// the port count is 1..MAX_PORTS, the stated length equals 7 plus twice the
// port bitmap size and fits both the buffer and MAX_BYTES, and the power
// switching mode is not the reserved code; otherwise every field is zero.
// Bytes beyond the seventh are counted only. No clearing pass after reset.
module usb_hub_descriptor_parser #(
    parameter int unsigned MAX_PORTS = 15,
    parameter int unsigned MAX_BYTES = 71
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hdp_in_if.sink       i_in,
    hdp_out_if.source    o_out
);

    logic          accept;
    hdp_pkg::t_hdr hdr;
    hdp_pkg::t_res res;
    hdp_pkg::t_res r_res;
    logic          r_out_valid;

    // a slot is free when empty or being emptied this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    hdp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_hdr       (hdr)
    );

    hdp_check #(
        .MAX_PORTS (MAX_PORTS),
        .MAX_BYTES (MAX_BYTES)
    ) u_check (
        .i_hdr (hdr),
        .o_res (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.last_byte) begin
            r_res <= res;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.valid_res            = r_res.valid_res;
    assign o_out.characteristics_word = r_res.characteristics_word;
    assign o_out.num_ports            = r_res.num_ports;
    assign o_out.power_good_time      = r_res.power_good_time;
    assign o_out.controller_current   = r_res.controller_current;
    assign o_out.per_port_power       = r_res.per_port_power;
    assign o_out.no_power_switch      = r_res.no_power_switch;
    assign o_out.compound_device      = r_res.compound_device;
    assign o_out.think_time           = r_res.think_time;
    assign o_out.multiple_tt          = r_res.multiple_tt;

endmodule
`default_nettype wire

/* src/hdp_capture.sv */
`default_nettype none
// Header latches and saturating byte counter; presents the header as it
// stands once the current word is included.
module hdp_capture (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    output hdp_pkg::t_hdr      o_hdr
);

    hdp_pkg::t_hdr r_hdr;
    hdp_pkg::t_hdr n_hdr;

    always_comb begin
        n_hdr = r_hdr;
        unique case (r_hdr.count)
            hdp_pkg::OFS_LEN:     n_hdr.len         = i_data_byte;
            hdp_pkg::OFS_TYPE:    n_hdr.typ         = i_data_byte;
            hdp_pkg::OFS_PORTS:   n_hdr.ports       = i_data_byte;
            hdp_pkg::OFS_CHAR_LO: n_hdr.char_w[7:0] = i_data_byte;
            hdp_pkg::OFS_CHAR_HI: n_hdr.char_w[15:8] = i_data_byte;
            hdp_pkg::OFS_PGOOD:   n_hdr.pgood       = i_data_byte;
            hdp_pkg::OFS_CURR:    n_hdr.curr        = i_data_byte;
            default:              ;
        endcase
        if (r_hdr.count != hdp_pkg::COUNT_MAX) begin
            n_hdr.count = r_hdr.count + 8'd1;
        end
    end

    assign o_hdr = n_hdr;

    // the final word closes the buffer: start afresh for the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_hdr <= '0;
            end else begin
                r_hdr <= n_hdr;
            end
        end
    end

endmodule
`default_nettype wire

/* src/hdp_check.sv */
`default_nettype none
// Descriptor checks and characteristics decode.
module hdp_check #(
    parameter int unsigned MAX_PORTS = 15,
    parameter int unsigned MAX_BYTES = 71
) (
    input  hdp_pkg::t_hdr i_hdr,
    output hdp_pkg::t_res o_res
);

    logic [8:0] ports_ext;
    logic [5:0] map_bytes;
    logic [7:0] required;
    logic [1:0] mode;
    logic       ok;

    always_comb begin
        // bitmap covers the ports plus the reserved bit 0
        ports_ext    = {1'b0, i_hdr.ports} + 9'd8;
        map_bytes    = ports_ext[8:3];
        required     = hdp_pkg::MIN_DESC_LEN + {1'b0, map_bytes, 1'b0};
        mode         = i_hdr.char_w[1:0];

        ok = (i_hdr.count >= hdp_pkg::MIN_DESC_LEN)
            && (i_hdr.typ == hdp_pkg::HUB_DESC_TYPE)
            && (i_hdr.ports != 8'd0)
            && (i_hdr.ports <= 8'(MAX_PORTS))
            && (i_hdr.len == required)
            && (i_hdr.count >= i_hdr.len)
            && (i_hdr.len <= 8'(MAX_BYTES))
            && (mode != hdp_pkg::PWR_BAD);

        o_res = '0;
        if (ok) begin
            o_res.valid_res            = 1'b1;
            o_res.characteristics_word = i_hdr.char_w;
            o_res.num_ports            = i_hdr.ports;
            o_res.power_good_time      = i_hdr.pgood;
            o_res.controller_current   = i_hdr.curr;
            o_res.per_port_power       = (mode == hdp_pkg::PWR_INDIV);
            o_res.no_power_switch      = (mode == hdp_pkg::PWR_NONE);
            o_res.compound_device      = i_hdr.char_w[hdp_pkg::COMPOUND_BIT];
            o_res.think_time           = i_hdr.char_w[hdp_pkg::THINK_LO +: 2];
            o_res.multiple_tt          = i_hdr.char_w[hdp_pkg::MULTI_TT_BIT];
        end
    end

endmodule
`default_nettype wire

/* src/hdp_checker.sv */
`default_nettype none
module hdp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_last_byte,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_valid_res,
    input wire logic [15:0] i_char_word,
    input wire logic [7:0]  i_num_ports,
    input wire logic [7:0]  i_pgood,
    input wire logic [7:0]  i_curr,
    input wire logic        i_ppp,
    input wire logic        i_nps,
    input wire logic        i_compound,
    input wire logic [1:0]  i_think,
    input wire logic        i_mtt
);

    // a stalled result word holds its flag, port count and characteristics word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_char_word)
            && $stable(i_valid_res) && $stable(i_num_ports)))
        else $error("result word changed while stalled");

    // every final byte taken yields a result word next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_last_byte) |=> i_out_valid)
        else $error("final byte gave no result word");

    // a failed descriptor reports nothing but the flag
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_valid_res) |-> (i_char_word == 16'd0 && i_num_ports == 8'd0
            && i_pgood == 8'd0 && i_curr == 8'd0 && !i_ppp && !i_nps && !i_compound
            && i_think == 2'd0 && !i_mtt))
        else $error("invalid descriptor with non-zero fields");

    // decoded bits agree with the characteristics word; the port count is non-zero and the mode is not reserved
    a_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_valid_res) |-> (i_num_ports != 8'd0
            && i_char_word[1:0] != 2'd3
            && i_ppp == (i_char_word[1:0] == 2'd1)
            && i_nps == (i_char_word[1:0] == 2'd2)
            && i_compound == i_char_word[2] && i_think == i_char_word[6:5]
            && i_mtt == i_char_word[7]))
        else $error("decoded fields disagree with characteristics");

endmodule

bind usb_hub_descriptor_parser hdp_checker u_hdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_last_byte (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_valid_res (o_out.valid_res),
    .i_char_word (o_out.characteristics_word),
    .i_num_ports (o_out.num_ports),
    .i_pgood     (o_out.power_good_time),
    .i_curr      (o_out.controller_current),
    .i_ppp       (o_out.per_port_power),
    .i_nps       (o_out.no_power_switch),
    .i_compound  (o_out.compound_device),
    .i_think     (o_out.think_time),
    .i_mtt       (o_out.multiple_tt)
);
`default_nettype wire
